// ===== rtl/core/obe_pkg.sv =====
// Shared constants and types for the octave band energy core.
package obe_pkg;

   // Number of octave bands reported per frame.
   localparam int OCTAVE_COUNT = 9;
   // Number of FFT bins in one frame.
   localparam int FRAME_BINS = 2048;

   // Width of the bin position counter.
   localparam int BIN_WIDTH = 16;
   // Width of the octave index.
   localparam int OCTAVE_WIDTH = 4;
   // Width of the signed bin components.
   localparam int SAMPLE_WIDTH = 32;
   // Width of a bin power and of the band energy.
   localparam int ENERGY_WIDTH = 64;

   // Band bookkeeping that travels with each bin through the pipeline.
   typedef struct packed {
      logic                    band_first;
      logic                    band_end;
      logic [OCTAVE_WIDTH-1:0] octave;
      logic                    last;
   } obe_tag_type;

endpackage

// ===== rtl/core/obe_front.sv =====
// Frame tracking and input register: decides which bins enter the band sums.
module obe_front
   import obe_pkg::*;
(
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0] req_re,
   input  logic signed [SAMPLE_WIDTH-1:0] req_im,
   input  logic                           req_frame_start,
   output logic                           a_valid,
   input  logic                           a_ready,
   output logic signed [SAMPLE_WIDTH-1:0] a_re,
   output logic signed [SAMPLE_WIDTH-1:0] a_im,
   output obe_tag_type                    a_tag
);

   logic [BIN_WIDTH-1:0]    bin_count_ff, bin_count_in;
   logic [OCTAVE_WIDTH-1:0] band_index_ff, band_index_in;
   logic                    frame_done_ff, frame_done_in;
   logic                    a_valid_ff, a_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] a_re_ff, a_im_ff;
   obe_tag_type             a_tag_ff, a_tag_in;

   logic [BIN_WIDTH-1:0]    cur_bin;
   logic [OCTAVE_WIDTH-1:0] cur_band;
   logic                    cur_done;
   logic [BIN_WIDTH:0]      bin_plus;
   logic [BIN_WIDTH-1:0]    first_bin;
   logic [BIN_WIDTH-1:0]    end_bin;
   logic [OCTAVE_WIDTH:0]   band_plus;
   logic                    in_band;
   logic                    transfer;

   // The input register is free when empty or when its item moves on.
   assign req_ready = !a_valid_ff || a_ready;
   assign transfer  = req_valid && req_ready;

   // A frame start restarts the frame at bin zero before the bin is counted.
   always_comb begin
      cur_bin   = req_frame_start ? '0 : bin_count_ff;
      cur_band  = req_frame_start ? '0 : band_index_ff;
      cur_done  = req_frame_start ? 1'b0 : frame_done_ff;
      bin_plus  = {1'b0, cur_bin} + (BIN_WIDTH+1)'(1);
      band_plus = {1'b0, cur_band} + (OCTAVE_WIDTH+1)'(1);
      first_bin = BIN_WIDTH'(1) << ((OCTAVE_WIDTH+1)'(cur_band) + (OCTAVE_WIDTH+1)'(1));
      end_bin   = (BIN_WIDTH'(1) << ((OCTAVE_WIDTH+1)'(cur_band) + (OCTAVE_WIDTH+1)'(2)))
                  - BIN_WIDTH'(1);
      in_band   = !cur_done && (cur_bin >= BIN_WIDTH'(2));

      a_tag_in.band_first = (cur_bin == first_bin);
      a_tag_in.band_end   = (cur_bin == end_bin);
      a_tag_in.octave     = cur_band;
      a_tag_in.last       = (cur_band == OCTAVE_WIDTH'(OCTAVE_COUNT - 1));

      bin_count_in  = bin_count_ff;
      band_index_in = band_index_ff;
      frame_done_in = frame_done_ff;
      if (transfer && !cur_done) begin
         bin_count_in  = bin_plus[BIN_WIDTH-1:0];
         band_index_in = cur_band;
         frame_done_in = 1'b0;
         if (in_band && a_tag_in.band_end) begin
            band_index_in = band_plus[OCTAVE_WIDTH-1:0];
            if (band_plus >= (OCTAVE_WIDTH+1)'(OCTAVE_COUNT)) begin
               frame_done_in = 1'b1;
            end
         end
         if (bin_plus >= (BIN_WIDTH+1)'(FRAME_BINS)) begin
            frame_done_in = 1'b1;
         end
      end

      a_valid_in = a_valid_ff;
      if (req_ready) begin
         a_valid_in = transfer && in_band;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         bin_count_ff  <= '0;
         band_index_ff <= '0;
         frame_done_ff <= 1'b1;
         a_valid_ff    <= 1'b0;
      end else begin
         bin_count_ff  <= bin_count_in;
         band_index_ff <= band_index_in;
         frame_done_ff <= frame_done_in;
         a_valid_ff    <= a_valid_in;
      end
   end

   // Payload of the input register.
   always_ff @(posedge clock) begin
      if (req_ready) begin
         a_re_ff  <= req_re;
         a_im_ff  <= req_im;
         a_tag_ff <= a_tag_in;
      end
   end

   assign a_valid = a_valid_ff;
   assign a_re    = a_re_ff;
   assign a_im    = a_im_ff;
   assign a_tag   = a_tag_ff;

endmodule

// ===== rtl/core/obe_power.sv =====
// Bin power pipeline: registered squares, then their registered sum.
module obe_power
   import obe_pkg::*;
(
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           a_valid,
   output logic                           a_ready,
   input  logic signed [SAMPLE_WIDTH-1:0] a_re,
   input  logic signed [SAMPLE_WIDTH-1:0] a_im,
   input  obe_tag_type                    a_tag,
   output logic                           c_valid,
   input  logic                           c_ready,
   output logic [ENERGY_WIDTH-1:0]        c_power,
   output obe_tag_type                    c_tag
);

   logic                           b_valid_ff, b_valid_in;
   logic signed [ENERGY_WIDTH-1:0] sq_re_ff, sq_im_ff, sq_re_in, sq_im_in;
   obe_tag_type                    b_tag_ff;
   logic                           c_valid_ff, c_valid_in;
   logic [ENERGY_WIDTH-1:0]        c_power_ff, c_power_in;
   obe_tag_type                    c_tag_ff;
   logic                           b_ready;

   // Stage readiness runs back from the accumulator.
   assign b_ready = !c_valid_ff || c_ready;
   assign a_ready = !b_valid_ff || b_ready;

   // Each square is a 32 by 32 signed product and never exceeds 2^62.
   assign sq_re_in = a_re * a_re;
   assign sq_im_in = a_im * a_im;
   // The sum of two squares never exceeds 2^63, so no carry is lost.
   assign c_power_in = ENERGY_WIDTH'(sq_re_ff) + ENERGY_WIDTH'(sq_im_ff);

   always_comb begin
      b_valid_in = b_valid_ff;
      if (a_ready) begin
         b_valid_in = a_valid;
      end
      c_valid_in = c_valid_ff;
      if (b_ready) begin
         c_valid_in = b_valid_ff;
      end
   end

   // Stage valid flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= b_valid_in;
         c_valid_ff <= c_valid_in;
      end
   end

   // Stage payloads.
   always_ff @(posedge clock) begin
      if (a_ready) begin
         sq_re_ff <= sq_re_in;
         sq_im_ff <= sq_im_in;
         b_tag_ff <= a_tag;
      end
      if (b_ready) begin
         c_power_ff <= c_power_in;
         c_tag_ff   <= b_tag_ff;
      end
   end

   assign c_valid = c_valid_ff;
   assign c_power = c_power_ff;
   assign c_tag   = c_tag_ff;

endmodule

// ===== rtl/core/obe_accum.sv =====
// Saturating band accumulator and result register.
module obe_accum
   import obe_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    c_valid,
   output logic                    c_ready,
   input  logic [ENERGY_WIDTH-1:0] c_power,
   input  obe_tag_type             c_tag,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [OCTAVE_WIDTH-1:0] rsp_octave,
   output logic [ENERGY_WIDTH-1:0] rsp_energy,
   output logic                    rsp_last_octave
);

   logic [ENERGY_WIDTH-1:0] acc_ff, acc_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [OCTAVE_WIDTH-1:0] rsp_octave_ff;
   logic [ENERGY_WIDTH-1:0] rsp_energy_ff;
   logic                    rsp_last_ff;
   logic [ENERGY_WIDTH:0]   sum;
   logic                    out_free;
   logic                    take;

   // Only a band's final bin needs room in the result register.
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign c_ready  = !c_valid || !c_tag.band_end || out_free;
   assign take     = c_valid && c_ready;

   // The first bin of a band starts a fresh sum; otherwise add and clamp.
   always_comb begin
      sum = {1'b0, acc_ff} + {1'b0, c_power};
      if (c_tag.band_first) begin
         acc_in = c_power;
      end else if (sum[ENERGY_WIDTH]) begin
         acc_in = '1;
      end else begin
         acc_in = sum[ENERGY_WIDTH-1:0];
      end

      rsp_valid_in = rsp_valid_ff;
      if (take && c_tag.band_end) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         acc_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            acc_ff <= acc_in;
         end
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (take && c_tag.band_end) begin
         rsp_octave_ff <= c_tag.octave;
         rsp_energy_ff <= acc_in;
         rsp_last_ff   <= c_tag.last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_octave      = rsp_octave_ff;
   assign rsp_energy      = rsp_energy_ff;
   assign rsp_last_octave = rsp_last_ff;

endmodule

// ===== rtl/core/octave_band_energy_core.sv =====
// Top level of the octave band energy core: FFT bins in, octave band energies out.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  req_re, req_im, req_frame_start
//   rsp      out        rsp_valid / rsp_ready  rsp_octave, rsp_energy, rsp_last_octave
//
// One bin is taken in every cycle while req_ready is high; the last bin of a band
// passes the input register, squares register and power register before its band
// result enters the result register in the accumulator.
// Reset is synchronous: the core then waits for a bin marked as a frame start.
// A result waiting in the result register stalls only a band's final bin; other
// bins still enter the accumulator, but a stalled final bin holds up those behind it.
module octave_band_energy_core
   import obe_pkg::*;
(
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0] req_re,
   input  logic signed [SAMPLE_WIDTH-1:0] req_im,
   input  logic                           req_frame_start,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [OCTAVE_WIDTH-1:0]        rsp_octave,
   output logic [ENERGY_WIDTH-1:0]        rsp_energy,
   output logic                           rsp_last_octave
);

   logic                           a_valid, a_ready;
   logic signed [SAMPLE_WIDTH-1:0] a_re, a_im;
   obe_tag_type                    a_tag;
   logic                           c_valid, c_ready;
   logic [ENERGY_WIDTH-1:0]        c_power;
   obe_tag_type                    c_tag;

   // Frame and band tracking.
   obe_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_re          (req_re),
      .req_im          (req_im),
      .req_frame_start (req_frame_start),
      .a_valid         (a_valid),
      .a_ready         (a_ready),
      .a_re            (a_re),
      .a_im            (a_im),
      .a_tag           (a_tag)
   );

   // Bin power.
   obe_power u_power (
      .clock   (clock),
      .reset   (reset),
      .a_valid (a_valid),
      .a_ready (a_ready),
      .a_re    (a_re),
      .a_im    (a_im),
      .a_tag   (a_tag),
      .c_valid (c_valid),
      .c_ready (c_ready),
      .c_power (c_power),
      .c_tag   (c_tag)
   );

   // Band sum and result register.
   obe_accum u_accum (
      .clock           (clock),
      .reset           (reset),
      .c_valid         (c_valid),
      .c_ready         (c_ready),
      .c_power         (c_power),
      .c_tag           (c_tag),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_octave      (rsp_octave),
      .rsp_energy      (rsp_energy),
      .rsp_last_octave (rsp_last_octave)
   );

   // A reported octave always lies within the configured band count.
   a_octave_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_octave < OCTAVE_WIDTH'(OCTAVE_COUNT)))
      else $error("octave index beyond the last band");

   // The last-octave mark goes with the final band and with no other.
   a_last_mark : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_octave == (rsp_octave == OCTAVE_WIDTH'(OCTAVE_COUNT - 1))))
      else $error("last-octave mark does not match the octave index");

   // No result survives a reset.
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

   // A band's final bin is held back only while the result register is occupied.
   a_end_stall : assert property (@(posedge clock) disable iff (reset)
      (c_valid && !c_ready) |-> (c_tag.band_end && rsp_valid && !rsp_ready))
      else $error("accumulator stalled without a pending result");

endmodule
